### rtl/pnmvt_pkg.sv
package pnmvt_pkg;

    // Command codes of an input word
    localparam logic CMD_SET   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIPE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_COUNT = 1'b1;
    localparam int CFG_DATA_W = 9;

    localparam int PIPE_COUNT_W = 9;
    localparam int STOP_COUNT_W = 5;
    localparam int NOTE_W       = 8;
    localparam int VEL_W        = 7;
    localparam int STOP_W       = 4;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic              command;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic [STOP_W-1:0] stop_index;
    } in_item_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note_out;
        logic [VEL_W-1:0]  pipe_velocity;
    } out_item_t;

    typedef struct packed {
        logic                    is_clear;
        logic [NOTE_W-1:0]       note;
        logic [VEL_W-1:0]        velocity;
        logic [STOP_W-1:0]       stop_index;
        logic [STOP_COUNT_W-1:0] scan_len;
    } queue_entry_t;

endpackage

### rtl/pnmvt_front.sv
module pnmvt_front #(
    parameter int NOTES = 256,
    parameter int STOPS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [pnmvt_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [pnmvt_pkg::CFG_DATA_W-1:0]      wr_data,
    input  logic                                  item_valid,
    input  pnmvt_pkg::in_item_t                   item,
    output logic                                  item_ready,
    input  logic                                  clearing,
    input  logic                                  q_full,
    output logic                                  push,
    output pnmvt_pkg::queue_entry_t               push_entry
);

    logic [pnmvt_pkg::PIPE_COUNT_W-1:0] pipe_count_reg, pipe_count_next;
    logic [pnmvt_pkg::STOP_COUNT_W-1:0] stop_count_reg, stop_count_next;
    logic note_ok;
    logic stop_ok;
    logic keep;
    logic [pnmvt_pkg::STOP_COUNT_W-1:0] scan_len;

    always_comb
    begin
        pipe_count_next = pipe_count_reg;
        stop_count_next = stop_count_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                pnmvt_pkg::CFG_PIPE_COUNT:
                    pipe_count_next = wr_data[pnmvt_pkg::PIPE_COUNT_W-1:0];
                pnmvt_pkg::CFG_STOP_COUNT:
                    stop_count_next = wr_data[pnmvt_pkg::STOP_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_count_reg <= '0;
            stop_count_reg <= '0;
        end
        else
        begin
            pipe_count_reg <= pipe_count_next;
            stop_count_reg <= stop_count_next;
        end
    end

    // Classify: drop sets outside the rank, keep clears and valid sets
    always_comb
    begin
        note_ok = ({1'b0, item.note} < pipe_count_reg) && (32'(item.note) < 32'(NOTES));
        stop_ok = ({1'b0, item.stop_index} < stop_count_reg)
                  && (32'(item.stop_index) < 32'(STOPS));
        if (32'(stop_count_reg) > 32'(STOPS))
            scan_len = pnmvt_pkg::STOP_COUNT_W'(STOPS);
        else
            scan_len = stop_count_reg;
        keep = (item.command == pnmvt_pkg::CMD_CLEAR) || (note_ok && stop_ok);
    end

    assign item_ready = !q_full && !clearing;
    assign push       = item_valid && item_ready && keep;

    always_comb
    begin
        push_entry.is_clear   = (item.command == pnmvt_pkg::CMD_CLEAR);
        push_entry.note       = item.note;
        push_entry.velocity   = item.velocity;
        push_entry.stop_index = item.stop_index;
        push_entry.scan_len   = scan_len;
    end

endmodule

### rtl/pnmvt_fifo.sv
module pnmvt_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  pnmvt_pkg::queue_entry_t push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output pnmvt_pkg::queue_entry_t head
);

    pnmvt_pkg::queue_entry_t entry_reg [pnmvt_pkg::QUEUE_DEPTH];
    logic [pnmvt_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pnmvt_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pnmvt_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full       = (count_reg == pnmvt_pkg::QCNT_W'(pnmvt_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (do_push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (do_pop ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### rtl/pnmvt_back.sv
module pnmvt_back #(
    parameter int NOTES = 256,
    parameter int STOPS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  pnmvt_pkg::queue_entry_t q_head,
    output logic                    pop,
    output logic                    clearing,
    output logic                    result_valid,
    input  logic                    result_ready,
    output pnmvt_pkg::out_item_t    result
);

    localparam int NA    = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam int SA    = (STOPS > 1) ? $clog2(STOPS) : 1;
    localparam int DEPTH = NOTES * STOPS;
    localparam int MA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = pnmvt_pkg::VEL_W;
    localparam int CW    = pnmvt_pkg::STOP_COUNT_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    function automatic logic [MA-1:0] entry_addr(input logic [NA-1:0] n, input logic [SA-1:0] s);
        entry_addr = MA'(n) * MA'(STOPS) + MA'(s);
    endfunction

    logic [2:0]    state_reg, state_next;
    logic [NA-1:0] clr_note_reg, clr_note_next;
    logic [SA-1:0] clr_stop_reg, clr_stop_next;
    pnmvt_pkg::queue_entry_t op_reg, op_next;
    logic [MA-1:0] addr_reg, addr_next;
    logic [MA-1:0] base_reg, base_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          pend_reg, pend_next;
    logic [VW-1:0] best_reg, best_next;
    logic [VW-1:0] max_reg, max_next;
    logic          out_valid_reg, out_valid_next;
    pnmvt_pkg::out_item_t out_reg, out_next;

    logic [VW-1:0] sv_mem [DEPTH];
    logic [VW-1:0] nm_mem [NOTES];
    logic [VW-1:0] sv_rd_reg;
    logic [VW-1:0] nm_rd_reg;

    logic          sv_we;
    logic [MA-1:0] sv_waddr;
    logic [VW-1:0] sv_wdata;
    logic [MA-1:0] sv_raddr;
    logic          nm_we;
    logic [NA-1:0] nm_waddr;
    logic [VW-1:0] nm_wdata;
    logic [NA-1:0] nm_raddr;
    logic          issue;

    assign clearing     = (state_reg == ST_CLEAR);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_note_next  = clr_note_reg;
        clr_stop_next  = clr_stop_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_next      = 1'b0;
        best_next      = best_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        issue          = 1'b0;
        sv_we          = 1'b0;
        sv_waddr       = addr_reg;
        sv_wdata       = op_reg.velocity;
        sv_raddr       = entry_addr(NA'(q_head.note), SA'(q_head.stop_index));
        nm_we          = 1'b0;
        nm_waddr       = NA'(op_reg.note);
        nm_wdata       = max_reg;
        nm_raddr       = NA'(q_head.note);

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one stop entry a cycle, the note maximum on each row start
                sv_we    = 1'b1;
                sv_waddr = entry_addr(clr_note_reg, clr_stop_reg);
                sv_wdata = '0;
                nm_we    = (clr_stop_reg == '0);
                nm_waddr = clr_note_reg;
                nm_wdata = '0;
                if (clr_stop_reg == SA'(STOPS - 1))
                begin
                    clr_stop_next = '0;
                    if (clr_note_reg == NA'(NOTES - 1))
                    begin
                        clr_note_next = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                        clr_note_next = clr_note_reg + 1'b1;
                end
                else
                    clr_stop_next = clr_stop_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop     = 1'b1;
                    op_next = q_head;
                    if (q_head.is_clear)
                    begin
                        clr_note_next = '0;
                        clr_stop_next = '0;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        addr_next  = entry_addr(NA'(q_head.note), SA'(q_head.stop_index));
                        base_next  = entry_addr(NA'(q_head.note), '0);
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                // Store the new entry, then decide how the maximum moves
                sv_we = 1'b1;
                if (!((op_reg.velocity > nm_rd_reg) || (op_reg.velocity < sv_rd_reg)))
                    state_next = ST_IDLE;
                else if (op_reg.velocity >= nm_rd_reg)
                begin
                    max_next   = op_reg.velocity;
                    state_next = ST_WRITE;
                end
                else
                begin
                    scan_cnt_next = '0;
                    best_next     = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // One read issued per cycle, data folded in the following cycle
                sv_raddr = base_reg + MA'(scan_cnt_reg);
                issue    = (scan_cnt_reg < op_reg.scan_len);
                pend_next = issue;
                if (issue)
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                if (pend_reg && (sv_rd_reg > best_reg))
                    best_next = sv_rd_reg;
                if (!issue && !pend_reg)
                begin
                    max_next   = best_reg;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    nm_we                  = 1'b1;
                    out_valid_next         = 1'b1;
                    out_next.note_out      = op_reg.note;
                    out_next.pipe_velocity = max_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_note_reg  <= '0;
            clr_stop_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_note_reg  <= clr_note_next;
            clr_stop_reg  <= clr_stop_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        base_reg     <= base_next;
        scan_cnt_reg <= scan_cnt_next;
        best_reg     <= best_next;
        max_reg      <= max_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (sv_we)
            sv_mem[sv_waddr] <= sv_wdata;
        sv_rd_reg <= sv_mem[sv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nm_we)
            nm_mem[nm_waddr] <= nm_wdata;
        nm_rd_reg <= nm_mem[nm_raddr];
    end

endmodule

### rtl/per_note_max_velocity_tracker_top.sv
// Per-note maximum velocity tracker for one rank of pipes.
// Configure pipe_count (index 0) and stop_count (index 1) through the write
// port while the block is idle; a write takes effect at once.
// Input channel (item_valid/item_ready): one word per key event. A set word
// stores one stop's velocity for one note; a clear word zeroes all stored
// velocities and note maxima. Output channel (result_valid/result_ready):
// one word (note_out, pipe_velocity) for each set that raises a note maximum or
// lowers a stored velocity; sets outside the rank and other sets give nothing.
// Sequencer: a set passes IDLE and EVAL when it needs no result, adds WRITE when
// the new velocity sets the maximum directly, and adds SCAN before WRITE when a
// drop forces a rescan. The result register loads in WRITE; the rescan reads
// one stop per cycle.
// A two-word command queue decouples input from the sequencer.
// Reset, and every clear word, starts a clearing pass over the velocity
// memory, one entry per cycle, NOTES*STOPS entries (4096 at defaults); item_ready
// stays low during it while configuration writes are still taken.
// A stalled receiver holds the result register; the sequencer keeps working
// until it needs to load a second result, and the queue absorbs two more words.
module per_note_max_velocity_tracker_top #(
    parameter int NOTES = 256,
    parameter int STOPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [pnmvt_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [pnmvt_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  pnmvt_pkg::in_item_t               item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output pnmvt_pkg::out_item_t              result
);

    logic                    clearing;
    logic                    q_full;
    logic                    push;
    pnmvt_pkg::queue_entry_t push_entry;
    logic                    pop;
    logic                    q_valid;
    pnmvt_pkg::queue_entry_t q_head;

    // Front: hold configuration, drop out-of-rank sets, enqueue the rest
    pnmvt_front #(
        .NOTES(NOTES),
        .STOPS(STOPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .clearing   (clearing),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: let the front take words while the back scans or stalls
    pnmvt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // Back: own both memories, update entries, rescan, clear, emit results
    pnmvt_back #(
        .NOTES(NOTES),
        .STOPS(STOPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### rtl/pnmvt_checker.sv
module pnmvt_checker #(
    parameter int NOTES = 256
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              wr_en,
    input logic [pnmvt_pkg::CFG_INDEX_W-1:0] wr_index,
    input logic [pnmvt_pkg::CFG_DATA_W-1:0]  wr_data,
    input logic                              item_valid,
    input logic                              item_ready,
    input pnmvt_pkg::in_item_t               item,
    input logic                              result_valid,
    input logic                              result_ready,
    input pnmvt_pkg::out_item_t              result
);

    logic [pnmvt_pkg::PIPE_COUNT_W-1:0] pipe_count_reg;

    // Shadow the pipe count as written on the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_count_reg <= '0;
        else if (wr_en && (wr_index == pnmvt_pkg::CFG_PIPE_COUNT))
            pipe_count_reg <= wr_data[pnmvt_pkg::PIPE_COUNT_W-1:0];
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_reset_exit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !item_ready && !result_valid)
        else $error("block not clearing after reset");

    a_note_in_rank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, result.note_out} < pipe_count_reg)
                         && (32'(result.note_out) < 32'(NOTES)))
        else $error("result for a note outside the rank");

    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("input word changed while waiting");

endmodule

bind per_note_max_velocity_tracker_top pnmvt_checker #(.NOTES(NOTES)) u_pnmvt_checker (.*);
